// ----- src/lrupr_pkg.sv -----
package lrupr_pkg;

    localparam int unsigned FRAME_COUNT_DEF = 4;
    localparam int unsigned PAGE_BITS_DEF   = 10;

    typedef struct packed {
        logic valid;
        logic found;
    } lrupr_link_t;

endpackage

// ----- src/lrupr_cell.sv -----
module lrupr_cell #(
    parameter int unsigned PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [PAGE_BITS-1:0]   ref_page,
    input  lrupr_pkg::lrupr_link_t prev_link,
    input  logic [PAGE_BITS-1:0]   prev_page,
    output lrupr_pkg::lrupr_link_t this_link,
    output logic [PAGE_BITS-1:0]   this_page
);
    import lrupr_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] page_next;
    logic                 match;
    logic                 shift;

    assign match = valid_reg && (page_reg == ref_page);
    assign shift = advance && !prev_link.found;

    always_comb
    begin
        valid_next = valid_reg;
        page_next  = page_reg;
        if (shift)
        begin
            valid_next = prev_link.valid;
            page_next  = prev_page;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign this_link.valid = valid_reg;
    assign this_link.found = prev_link.found || match;
    assign this_page       = page_reg;

endmodule

// ----- src/lru_page_replacement.sv -----
// Channel  | Handshake             | Beat
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_ready   | page_number
// out      | out_valid / out_ready | hit, evicted, evicted_page, occupied_count
//
// One reference per cycle while in_ready; its result is registered on the next cycle.
// Cells form a recency stack, newest first; a beat shifts cells down to a hit, or all.
// The last cell holds the least recent page, which leaves the chain on a full miss.
// Reset clears every valid bit and the occupancy count; no clearing pass.
// in_ready drops only while a result waits and out_ready is low.
module lru_page_replacement #(
    parameter int unsigned FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
    parameter int unsigned PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF,
    localparam int unsigned COUNT_W    = $clog2(FRAME_COUNT + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PAGE_BITS-1:0] page_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit,
    output logic                 evicted,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [COUNT_W-1:0]   occupied_count
);
    import lrupr_pkg::*;

    lrupr_link_t          link [FRAME_COUNT+1];
    logic [PAGE_BITS-1:0] page [FRAME_COUNT+1];

    logic                 accept;
    logic                 hit_now;
    logic                 evict_now;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic                 evicted_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign link[0].valid = 1'b1;
    assign link[0].found = 1'b0;
    assign page[0]       = page_number;

    for (genvar i = 0; i < FRAME_COUNT; i++)
    begin : g_cell
        lrupr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (accept),
            .ref_page  (page_number),
            .prev_link (link[i]),
            .prev_page (page[i]),
            .this_link (link[i+1]),
            .this_page (page[i+1])
        );
    end

    assign hit_now   = link[FRAME_COUNT].found;
    assign evict_now = !hit_now && link[FRAME_COUNT].valid;

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (!hit_now && !link[FRAME_COUNT].valid)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg          <= hit_now;
            evicted_reg      <= evict_now;
            evicted_page_reg <= evict_now ? page[FRAME_COUNT] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign evicted        = evicted_reg;
    assign evicted_page   = evicted_page_reg;
    assign occupied_count = count_reg;

endmodule

// ----- src/lrupr_checker.sv -----
module lrupr_checker #(
    parameter int unsigned FRAME_COUNT = lrupr_pkg::FRAME_COUNT_DEF,
    parameter int unsigned PAGE_BITS   = lrupr_pkg::PAGE_BITS_DEF,
    localparam int unsigned COUNT_W    = $clog2(FRAME_COUNT + 1)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [PAGE_BITS-1:0] page_number,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 hit,
    input logic                 evicted,
    input logic [PAGE_BITS-1:0] evicted_page,
    input logic [COUNT_W-1:0]   occupied_count
);
    import lrupr_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(page_number))
        else $error("reference beat changed while stalled");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(evicted)
            && $stable(evicted_page) && $stable(occupied_count))
        else $error("result beat changed while stalled");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit && (occupied_count == COUNT_W'(FRAME_COUNT)))
        else $error("eviction without a full miss");

    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> evicted_page == '0)
        else $error("evicted page not zero");

    a_hit_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> occupied_count != '0)
        else $error("hit with no resident page");

endmodule

bind lru_page_replacement lrupr_checker #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS)
) u_lrupr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .page_number    (page_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .evicted        (evicted),
    .evicted_page   (evicted_page),
    .occupied_count (occupied_count)
);

// ----- test/tb_lru_page_replacement.sv -----
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int unsigned FRAMES  = FRAME_COUNT_DEF;
    localparam int unsigned PAGE_W  = PAGE_BITS_DEF;
    localparam int unsigned COUNT_W = $clog2(FRAMES + 1);

    typedef struct {
        logic               hit;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] occupied_count;
    } page_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [PAGE_W-1:0]  page_number = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               hit;
    logic               evicted;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] occupied_count;

    logic [PAGE_W-1:0]  model_page [FRAMES];
    logic               model_live [FRAMES];
    int unsigned        model_rank [FRAMES];
    int unsigned        model_count;

    page_result_t       expected_results [$];
    int                 error_count;
    int                 refs_sent;
    int                 results_seen;
    int                 hits_seen;
    int                 evictions_seen;
    bit                 src_idle_on;
    bit                 sink_idle_on;
    int                 sink_wait;

    lru_page_replacement u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .page_number    (page_number),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .evicted        (evicted),
        .evicted_page   (evicted_page),
        .occupied_count (occupied_count)
    );

    always #1 clk = ~clk;

    function automatic void age_younger_than(input int unsigned limit);
        for (int i = 0; i < FRAMES; i++)
        begin
            if (model_live[i] && model_rank[i] < limit)
                model_rank[i]++;
        end
    endfunction

    function automatic page_result_t lru_next_result(input logic [PAGE_W-1:0] pg);
        page_result_t r;
        int           slot;
        int unsigned  worst;
        r.hit          = 1'b0;
        r.evicted      = 1'b0;
        r.evicted_page = '0;
        slot = -1;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (slot < 0 && model_live[i] && model_page[i] == pg)
                slot = i;
        end
        if (slot >= 0)
        begin
            r.hit = 1'b1;
            age_younger_than(model_rank[slot]);
            model_rank[slot] = 0;
        end
        else
        begin
            for (int i = 0; i < FRAMES; i++)
            begin
                if (slot < 0 && !model_live[i])
                    slot = i;
            end
            if (slot >= 0)
            begin
                age_younger_than(FRAMES);
                model_live[slot] = 1'b1;
                model_page[slot] = pg;
                model_rank[slot] = 0;
                model_count++;
            end
            else
            begin
                worst = 0;
                slot  = 0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (model_rank[i] > worst)
                    begin
                        worst = model_rank[i];
                        slot  = i;
                    end
                end
                r.evicted      = 1'b1;
                r.evicted_page = model_page[slot];
                age_younger_than(model_rank[slot]);
                model_page[slot] = pg;
                model_rank[slot] = 0;
            end
        end
        r.occupied_count = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // Hold the beat until accepted; predict at the accepting edge.
    task automatic send_reference(input logic [PAGE_W-1:0] pg);
        int gap;
        gap = src_idle_on ? int'($urandom_range(0, 13)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        page_number <= pg;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(lru_next_result(pg));
        refs_sent++;
    endtask

    always @(posedge clk)
    begin
        page_result_t exp_r;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no reference outstanding");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.hit) hits_seen++;
                    if (exp_r.evicted) evictions_seen++;
                    if (hit !== exp_r.hit)
                    begin
                        $error("hit: expected %0d, got %0d", exp_r.hit, hit);
                        error_count++;
                    end
                    if (evicted !== exp_r.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", exp_r.evicted, evicted);
                        error_count++;
                    end
                    if (evicted_page !== exp_r.evicted_page)
                    begin
                        $error("evicted_page: expected %0d, got %0d",
                               exp_r.evicted_page, evicted_page);
                        error_count++;
                    end
                    if (occupied_count !== exp_r.occupied_count)
                    begin
                        $error("occupied_count: expected %0d, got %0d",
                               exp_r.occupied_count, occupied_count);
                        error_count++;
                    end
                end
                sink_wait = sink_idle_on ? int'($urandom_range(0, 13)) : 0;
                out_ready <= (sink_wait == 0);
            end
            else if (!out_ready)
            begin
                if (sink_wait > 1)
                    sink_wait--;
                else
                begin
                    sink_wait = 0;
                    out_ready <= 1'b1;
                end
            end
        end
    end

    task automatic test_directed_sequence();
        logic [PAGE_W-1:0] seq [] = '{
            10'd0, 10'd1023, 10'd0, 10'd0, 10'd341, 10'd682, 10'd1023,
            10'd5, 10'd0, 10'd341, 10'd682, 10'd6, 10'd7, 10'd8, 10'd9,
            10'd9, 10'd6, 10'd1023, 10'd512, 10'd8, 10'd7, 10'd9, 10'd1
        };
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        foreach (seq[i])
        begin
            if (i == 12)
            begin
                src_idle_on  = 1'b1;
                sink_idle_on = 1'b1;
            end
            send_reference(seq[i]);
        end
    endtask

    task automatic test_working_set(input int n_refs);
        logic [PAGE_W-1:0] pool [6];
        int                pool_size;
        pool_size = 3;
        for (int n = 0; n < n_refs; n++)
        begin
            if (n % 48 == 0)
            begin
                pool_size = int'($urandom_range(3, 6));
                foreach (pool[k])
                    pool[k] = PAGE_W'($urandom_range(0, 1023));
                src_idle_on  = ($urandom_range(0, 2) != 0);
                sink_idle_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 7) == 0)
                send_reference(PAGE_W'($urandom_range(0, 1023)));
            else
                send_reference(pool[$urandom_range(0, pool_size - 1)]);
        end
    endtask

    task automatic test_scattered_pages(input int n_refs);
        for (int n = 0; n < n_refs; n++)
        begin
            if (n % 64 == 0)
            begin
                src_idle_on  = ($urandom_range(0, 1) != 0);
                sink_idle_on = ($urandom_range(0, 1) != 0);
            end
            send_reference(PAGE_W'($urandom_range(0, 1023)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            model_page[i] = '0;
            model_live[i] = 1'b0;
            model_rank[i] = 0;
        end
        model_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sequence();
        test_working_set(1000);
        test_scattered_pages(230);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d page references, checked %0d results", refs_sent, results_seen);
        $display("Results covered %0d hits and %0d evictions", hits_seen, evictions_seen);
        if (error_count == 0)
            $display("tb_lru_page_replacement: PASS");
        else
            $display("tb_lru_page_replacement: FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("tb_lru_page_replacement: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lru_page_replacement.sv
src/lrupr_checker.sv
test/tb_lru_page_replacement.sv
